/* rtl/bwp_pkg.sv */
// ----------------------------------------------------------------------------
// bwp_pkg
// Shared types, constants and the charge-level lookup for the battery window
// averager.
// ----------------------------------------------------------------------------
package bwp_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int PERCENT_W  = 7;
    localparam int MARK_COUNT = 10;

    localparam logic [SAMPLE_W-1:0]  LEVEL_LOW_MV  = 16'd3500;
    localparam logic [SAMPLE_W-1:0]  LEVEL_HIGH_MV = 16'd4010;
    localparam logic [PERCENT_W-1:0] LEVEL_EMPTY   = 7'd0;
    localparam logic [PERCENT_W-1:0] LEVEL_FULL    = 7'd100;
    localparam logic [PERCENT_W-1:0] LEVEL_STEP    = 7'd10;

    typedef logic [SAMPLE_W-1:0] mark_table_t [MARK_COUNT];

    localparam mark_table_t LEVEL_MARKS = '{
        16'd3500, 16'd3550, 16'd3600, 16'd3680, 16'd3730,
        16'd3770, 16'd3820, 16'd3880, 16'd3950, 16'd4010
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_DELIVER
    } state_t;

    // Charge level in steps of ten; a mean exactly on a mark does not count
    // as above it.
    function automatic logic [PERCENT_W-1:0] level_of(input logic [SAMPLE_W-1:0] mean);
        logic [PERCENT_W-1:0] below;
        logic [PERCENT_W-1:0] level;
        below = '0;
        for (int k = 0; k < MARK_COUNT; k++)
        begin
            if (LEVEL_MARKS[k] < mean)
            begin
                below = below + 7'd1;
            end
        end
        if (mean < LEVEL_LOW_MV)
        begin
            level = LEVEL_EMPTY;
        end
        else if (mean > LEVEL_HIGH_MV)
        begin
            level = LEVEL_FULL;
        end
        else
        begin
            level = 7'(LEVEL_STEP * (below + 7'd1));
        end
        return level;
    endfunction

endpackage

/* rtl/bwp_if.sv */
// ----------------------------------------------------------------------------
// bwp_if
// Valid/ready channels for the battery window averager: samples in, results
// out.
// ----------------------------------------------------------------------------
interface bwp_sample_if;
    logic                          valid;
    logic                          ready;
    logic [bwp_pkg::SAMPLE_W-1:0]  sample_mv;

    modport source (output valid, output sample_mv, input ready);
    modport sink   (input valid, input sample_mv, output ready);
endinterface

interface bwp_result_if;
    logic                          valid;
    logic                          ready;
    logic [bwp_pkg::SAMPLE_W-1:0]  average_mv;
    logic [bwp_pkg::PERCENT_W-1:0] charge_percent;

    modport source (output valid, output average_mv, output charge_percent, input ready);
    modport sink   (input valid, input average_mv, input charge_percent, output ready);
endinterface

/* rtl/bwp_ram.sv */
// ----------------------------------------------------------------------------
// bwp_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bwp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/bwp_div.sv */
// ----------------------------------------------------------------------------
// bwp_div
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bwp_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 5,
    localparam int CNT_W     = $clog2(DIVIDEND_W + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg,    busy_next;
    logic                  done_reg,    done_next;
    logic [CNT_W-1:0]      cnt_reg,     cnt_next;
    logic [DIVIDEND_W-1:0] dq_reg,      dq_next;
    logic [DIVISOR_W-1:0]  rem_reg,     rem_next;
    logic [DIVISOR_W-1:0]  divisor_reg, divisor_next;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // The dividend shifts out of the top of dq_reg while quotient bits shift
    // in at the bottom.
    assign trial = {rem_reg, dq_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        dq_next      = dq_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = CNT_W'(DIVIDEND_W);
            dq_next      = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end
        else if (busy_reg)
        begin
            dq_next  = {dq_reg[DIVIDEND_W-2:0], fits};
            rem_next = fits ? DIVISOR_W'(trial - {1'b0, divisor_reg}) : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg      <= dq_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

/* rtl/battery_window_percent.sv */
// ----------------------------------------------------------------------------
// battery_window_percent
// Sliding-window battery voltage averager with a charge-level lookup.
// ----------------------------------------------------------------------------
// One word on the sample channel carries a voltage sample in millivolts. It
// goes into a ring of the last WINDOW samples, and every sample yields one
// word on the result channel: the truncated mean of the held samples and a
// charge level from 0 to 100 in steps of ten.
// The sample channel takes a word only while the block is idle. On
// acceptance the slot about to be overwritten is read, then the running
// total and fill count are updated, then a restoring divider yields the
// mean at one bit per cycle from the running total (20 bits wide for a
// window of 16), and then the result register is loaded. A new sample is
// taken once the block is back in idle.
// The result register holds its word while the receiver stalls, and the
// block already accepts the next sample; that item waits only at its last
// step until the register is free.
// Reset empties the window: fill count, running total and write slot go to
// zero. A ring slot's read value is used only once every slot has been written.
// ----------------------------------------------------------------------------
module battery_window_percent #(
    parameter int WINDOW = 16
) (
    input  logic clk,
    input  logic rst_n,
    bwp_sample_if.sink   sample,
    bwp_result_if.source result
);

    localparam int SW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW = $clog2(WINDOW + 1);
    localparam int TW = $clog2(WINDOW * 65535 + 1);
    localparam int DW = bwp_pkg::SAMPLE_W;
    localparam int PW = bwp_pkg::PERCENT_W;

    bwp_pkg::state_t state_reg, state_next;

    logic [SW-1:0] slot_reg,   slot_next;
    logic [CW-1:0] fill_reg,   fill_next;
    logic [TW-1:0] total_reg,  total_next;
    logic [DW-1:0] sample_reg;
    logic [DW-1:0] avg_reg;
    logic [PW-1:0] pct_reg;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          in_ready;
    logic          load_out;
    logic          div_start;
    logic          div_done;
    logic [TW-1:0] quotient;
    logic [DW-1:0] evicted;
    logic          window_full;
    logic [DW-1:0] mean;

    assign accept      = sample.valid && in_ready;
    assign window_full = fill_reg == CW'(WINDOW);
    assign mean        = quotient[DW-1:0];

    bwp_ram #(
        .WIDTH (DW),
        .DEPTH (WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (state_reg == bwp_pkg::ST_UPDATE),
        .waddr (slot_reg),
        .wdata (sample_reg),
        .raddr (slot_reg),
        .rdata (evicted)
    );

    bwp_div #(
        .DIVIDEND_W (TW),
        .DIVISOR_W  (CW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (fill_next),
        .done     (div_done),
        .quotient (quotient)
    );

    // Window bookkeeping; the evicted slot was read on the accepting edge.
    always_comb
    begin
        slot_next  = slot_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        if (state_reg == bwp_pkg::ST_UPDATE)
        begin
            if (window_full)
            begin
                total_next = total_reg - TW'(evicted) + TW'(sample_reg);
            end
            else
            begin
                fill_next  = fill_reg + CW'(1);
                total_next = total_reg + TW'(sample_reg);
            end
            slot_next = (slot_reg == SW'(WINDOW - 1)) ? '0 : slot_reg + SW'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bwp_pkg::ST_IDLE:
            begin
                if (sample.valid)
                begin
                    state_next = bwp_pkg::ST_UPDATE;
                end
            end
            bwp_pkg::ST_UPDATE:
            begin
                state_next = bwp_pkg::ST_DIVIDE;
            end
            bwp_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = bwp_pkg::ST_DELIVER;
                end
            end
            bwp_pkg::ST_DELIVER:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = bwp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bwp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready  = state_reg == bwp_pkg::ST_IDLE;
        div_start = state_reg == bwp_pkg::ST_UPDATE;
        load_out  = (state_reg == bwp_pkg::ST_DELIVER) && (!out_valid_reg || result.ready);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bwp_pkg::ST_IDLE;
            slot_reg      <= '0;
            fill_reg      <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            fill_reg      <= fill_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sample.sample_mv;
        end
        if (load_out)
        begin
            avg_reg <= mean;
            pct_reg <= bwp_pkg::level_of(mean);
        end
    end

    assign sample.ready          = in_ready;
    assign result.valid          = out_valid_reg;
    assign result.average_mv     = avg_reg;
    assign result.charge_percent = pct_reg;

    a_fill_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW))
        else $error("fill count exceeds the window");

    a_slot_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        32'(slot_reg) < WINDOW)
        else $error("write slot outside the window");

    a_total_bounded : assert property (@(posedge clk) disable iff (!rst_n)
        32'(total_reg) <= 32'(fill_reg) * 32'd65535)
        else $error("running total larger than the held samples allow");

    a_accept_updates : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == bwp_pkg::ST_UPDATE)
        else $error("accepted sample did not reach the update step");

    a_done_in_divide : assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == bwp_pkg::ST_DIVIDE)
        else $error("divider finished outside the divide step");

endmodule
